FILE: rtl/ism_pkg.sv
// ============================================================================
// Integer stack machine package
// Shared sizes, operation and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
package ism_pkg;

   // Number of entries the stack can hold.
   localparam int STACK_DEPTH = 64;

   // Width of the internal entry counter, wide enough to hold STACK_DEPTH.
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   // Width of a memory address.
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Fixed field widths.
   localparam int VALUE_W = 32;
   localparam int ENTRY_W = 7;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_ADD  = 2'd2,
      OP_SWAP = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_TOO_FEW   = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;   // capture the incoming transaction
      logic exec_en;   // apply the operation to the cached top and the memory
      logic fill_en;   // reload the second entry from memory
      logic emit_en;   // load the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_fill; // the operation leaves a hole in the second entry
   } dp_status_type;

endpackage

FILE: rtl/ism_datapath.sv
// ============================================================================
// Integer stack machine datapath
// Holds the top two entries in registers, the deeper entries in a memory,
// the entry count and the result register.
// ============================================================================
module ism_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ism_pkg::ctrl_cmd_type              cmd,
   output ism_pkg::dp_status_type             dp_status,
   input  logic [ism_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [ism_pkg::VALUE_W-1:0] req_value,
   output logic [ism_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ism_pkg::VALUE_W-1:0] rsp_top_value,
   output logic [ism_pkg::ENTRY_W-1:0]        rsp_entry_count
);

   // Deeper entries; entry k of the stack lives at address k.
   logic [ism_pkg::VALUE_W-1:0] stack_mem [ism_pkg::STACK_DEPTH];

   ism_pkg::op_type                 op_ff;
   logic [ism_pkg::VALUE_W-1:0]     value_ff;
   logic [ism_pkg::VALUE_W-1:0]     tos_ff;
   logic [ism_pkg::VALUE_W-1:0]     nos_ff;
   logic [ism_pkg::CNT_W-1:0]       count_ff;
   logic [ism_pkg::CNT_W-1:0]       count_in;
   ism_pkg::status_type             stat_ff;
   logic [ism_pkg::VALUE_W-1:0]     rd_data_ff;
   logic [ism_pkg::STAT_W-1:0]      rsp_status_ff;
   logic [ism_pkg::VALUE_W-1:0]     rsp_top_ff;
   logic [ism_pkg::ENTRY_W-1:0]     rsp_count_ff;

   logic                            is_full;
   logic                            is_empty;
   logic                            has_two;
   logic [ism_pkg::ADDR_W-1:0]      wr_addr;
   logic [ism_pkg::ADDR_W-1:0]      rd_addr;
   logic                            wr_en;

   assign is_full  = (count_ff == ism_pkg::CNT_W'(ism_pkg::STACK_DEPTH));
   assign is_empty = (count_ff == '0);
   assign has_two  = (count_ff >= ism_pkg::CNT_W'(2));

   // The second entry spills to address count-2 on a push; the entry that
   // becomes the new second one after a pop or add sits at count-3.
   assign wr_addr = ism_pkg::ADDR_W'(count_ff - ism_pkg::CNT_W'(2));
   assign rd_addr = ism_pkg::ADDR_W'(count_ff - ism_pkg::CNT_W'(3));
   assign wr_en   = cmd.exec_en && (op_ff == ism_pkg::OP_PUSH) && !is_full && has_two;

   assign dp_status.need_fill = ((op_ff == ism_pkg::OP_POP) || (op_ff == ism_pkg::OP_ADD))
                                && (count_ff >= ism_pkg::CNT_W'(3));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= nos_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.exec_en) begin
         unique case (op_ff)
            ism_pkg::OP_PUSH: begin
               if (!is_full) begin
                  count_in = count_ff + ism_pkg::CNT_W'(1);
               end
            end
            ism_pkg::OP_POP: begin
               if (!is_empty) begin
                  count_in = count_ff - ism_pkg::CNT_W'(1);
               end
            end
            ism_pkg::OP_ADD: begin
               if (has_two) begin
                  count_in = count_ff - ism_pkg::CNT_W'(1);
               end
            end
            ism_pkg::OP_SWAP: begin
               count_in = count_ff;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         op_ff    <= ism_pkg::op_type'(req_mode);
         value_ff <= req_value;
      end
      if (cmd.exec_en) begin
         unique case (op_ff)
            ism_pkg::OP_PUSH: begin
               if (is_full) begin
                  stat_ff <= ism_pkg::ST_OVERFLOW;
               end else begin
                  stat_ff <= ism_pkg::ST_OK;
                  nos_ff  <= tos_ff;
                  tos_ff  <= value_ff;
               end
            end
            ism_pkg::OP_POP: begin
               if (is_empty) begin
                  stat_ff <= ism_pkg::ST_UNDERFLOW;
               end else begin
                  stat_ff <= ism_pkg::ST_OK;
                  tos_ff  <= nos_ff;
               end
            end
            ism_pkg::OP_ADD: begin
               if (!has_two) begin
                  stat_ff <= ism_pkg::ST_TOO_FEW;
               end else begin
                  stat_ff <= ism_pkg::ST_OK;
                  tos_ff  <= tos_ff + nos_ff;
               end
            end
            ism_pkg::OP_SWAP: begin
               if (!has_two) begin
                  stat_ff <= ism_pkg::ST_TOO_FEW;
               end else begin
                  stat_ff <= ism_pkg::ST_OK;
                  tos_ff  <= nos_ff;
                  nos_ff  <= tos_ff;
               end
            end
            default: begin
               stat_ff <= ism_pkg::ST_OK;
            end
         endcase
      end
      if (cmd.fill_en) begin
         nos_ff <= rd_data_ff;
      end
      if (cmd.emit_en) begin
         rsp_status_ff <= stat_ff;
         rsp_top_ff    <= is_empty ? '0 : tos_ff;
         rsp_count_ff  <= ism_pkg::ENTRY_W'(count_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/ism_ctrl.sv
// ============================================================================
// Integer stack machine controller
// Sequences one transaction at a time through execute, optional refill of
// the second entry, and hand-off to the result register.
// ============================================================================
module ism_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ism_pkg::dp_status_type dp_status,
   output ism_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd.load_en = req_valid && req_ready_ff;
   assign cmd.exec_en = (state_ff == S_EXEC);
   assign cmd.fill_en = (state_ff == S_FILL);
   assign cmd.emit_en = (state_ff == S_EMIT) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= S_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               state_ff <= dp_status.need_fill ? S_FILL : S_EMIT;
            end
            S_FILL: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (slot_free) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/integer_stack_machine_core.sv
// ============================================================================
// Integer stack machine core
// A bounded LIFO of signed 32-bit integers with push, pop, add and swap.
// ============================================================================
// Sequencing: an accepted transaction is executed and handed to the result
// register; only pop or add that leave two or more entries pass through a
// refill state between, for the registered read of the entry memory that
// refills the second cached entry. One transaction is in flight at a time, and
// the result register is loaded only once the previous result is taken.
// Reset is synchronous and active high; it empties the stack. Memory contents
// are not cleared, since no entry is read before it has been written.
// ============================================================================
module integer_stack_machine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ism_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [ism_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ism_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [ism_pkg::VALUE_W-1:0] rsp_top_value,
   output logic [ism_pkg::ENTRY_W-1:0]        rsp_entry_count
);

   // The controller sequences each transaction and owns both handshakes;
   // the datapath owns the stack contents and the result payload.
   ism_pkg::ctrl_cmd_type  cmd;
   ism_pkg::dp_status_type dp_status;

   ism_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // The top two entries are cached in registers so that push and swap
   // never touch the memory read port; only a pop or add that exposes a
   // deeper entry passes through the refill state for the memory read.
   ism_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count)
   );

   // Only one transaction is in flight, so acceptance closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a transaction is in flight");

   // An empty stack reports a zero top value.
   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_entry_count == '0)
       && (rsp_status != ism_pkg::ST_OVERFLOW)) |-> (rsp_top_value == '0))
      else $error("nonzero top value reported for an empty stack");

   // Overflow is only reported with the stack full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ism_pkg::ST_OVERFLOW))
      |-> (rsp_entry_count == ism_pkg::ENTRY_W'(ism_pkg::STACK_DEPTH)))
      else $error("overflow reported while the stack is not full");

   // Underflow is only reported with the stack empty.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ism_pkg::ST_UNDERFLOW)) |-> (rsp_entry_count == '0))
      else $error("underflow reported while the stack holds entries");

endmodule
